// ----- rtl/core/matrix_multiply_4x4_defines.svh -----
// Assertion helpers for the matrix multiplier.
`ifndef MATRIX_MULTIPLY_4X4_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define MM4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mm4 check failed");
// checked during reset too
`define MM4_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mm4 reset check failed");
`else
`define MM4_ASSERT(lbl, prop)
`define MM4_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- rtl/core/mm4_pkg.sv -----
package mm4_pkg;

  localparam int MM4_FRAC_BITS = 16;
  localparam int ELEM_W        = 32;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;
  localparam int DIM           = 4;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MUL  = 1'b1
  } opcode_t;

  // column write into the current matrix
  typedef struct packed {
    logic                wr;
    logic [1:0]          col;
    elem_t [DIM-1:0]     data;
  } col_wr_t;

  // retiring product column, optionally committed
  typedef struct packed {
    logic                wr;
    logic                commit;
    logic [1:0]          col;
    elem_t [DIM-1:0]     data;
  } pend_wr_t;

endpackage

// ----- rtl/core/mm4_in_if.sv -----
interface mm4_in_if;
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [1:0]            col_index;
  mm4_pkg::elem_t        elem_x;
  mm4_pkg::elem_t        elem_y;
  mm4_pkg::elem_t        elem_z;
  mm4_pkg::elem_t        elem_w;
  logic                  commit;

  modport source (
    output valid, opcode, col_index, elem_x, elem_y, elem_z, elem_w, commit,
    input  ready
  );
  modport sink (
    input  valid, opcode, col_index, elem_x, elem_y, elem_z, elem_w, commit,
    output ready
  );
endinterface

// ----- rtl/core/mm4_out_if.sv -----
interface mm4_out_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            out_col;
  mm4_pkg::elem_t        res_x;
  mm4_pkg::elem_t        res_y;
  mm4_pkg::elem_t        res_z;
  mm4_pkg::elem_t        res_w;
  logic                  saturated;

  modport source (
    output valid, out_col, res_x, res_y, res_z, res_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_col, res_x, res_y, res_z, res_w, saturated,
    output ready
  );
endinterface

// ----- rtl/core/mm4_lane.sv -----
// One matrix row: four products, pairwise sums, then round and clip.
module mm4_lane #(
  parameter int FRAC_BITS = mm4_pkg::MM4_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  en_a,
  input  logic                                  en_b,
  input  mm4_pkg::elem_t [mm4_pkg::DIM-1:0]     m,
  input  mm4_pkg::elem_t [mm4_pkg::DIM-1:0]     v,
  output mm4_pkg::elem_t                        res,
  output logic                                  clip
);

  localparam logic signed [mm4_pkg::SUM_W-1:0] RND =
    mm4_pkg::SUM_W'(1) << (FRAC_BITS - 1);
  localparam mm4_pkg::elem_t MAX_VAL = {1'b0, {(mm4_pkg::ELEM_W-1){1'b1}}};
  localparam mm4_pkg::elem_t MIN_VAL = {1'b1, {(mm4_pkg::ELEM_W-1){1'b0}}};

  logic signed [mm4_pkg::PROD_W-1:0] prod [mm4_pkg::DIM];
  logic signed [mm4_pkg::PAIR_W-1:0] pair0, pair1;
  logic signed [mm4_pkg::SUM_W-1:0]  sum, shifted;
  logic [mm4_pkg::SUM_W-mm4_pkg::ELEM_W:0] top_bits;

  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int k = 0; k < mm4_pkg::DIM; k++) begin
        prod[k] <= m[k] * v[k];
      end
    end
    if (en_b) begin
      pair0 <= mm4_pkg::PAIR_W'(prod[0]) + mm4_pkg::PAIR_W'(prod[1]);
      pair1 <= mm4_pkg::PAIR_W'(prod[2]) + mm4_pkg::PAIR_W'(prod[3]);
    end
  end

  // round half up, floor shift, then clip to 32 bits
  always_comb begin
    sum      = mm4_pkg::SUM_W'(pair0) + mm4_pkg::SUM_W'(pair1) + RND;
    shifted  = sum >>> FRAC_BITS;
    top_bits = shifted[mm4_pkg::SUM_W-1:mm4_pkg::ELEM_W-1];
    clip     = !((&top_bits) || !(|top_bits));
    if (clip) begin
      res = shifted[mm4_pkg::SUM_W-1] ? MIN_VAL : MAX_VAL;
    end else begin
      res = shifted[mm4_pkg::ELEM_W-1:0];
    end
  end

endmodule

// ----- rtl/core/mm4_store.sv -----
// Current matrix and pending product store, column-major (col*4+row).
module mm4_store #(
  parameter int FRAC_BITS = mm4_pkg::MM4_FRAC_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  mm4_pkg::col_wr_t                          load,
  input  mm4_pkg::pend_wr_t                         pend,
  output mm4_pkg::elem_t [mm4_pkg::DIM*mm4_pkg::DIM-1:0] mat
);

  localparam int NUM = mm4_pkg::DIM * mm4_pkg::DIM;
  localparam mm4_pkg::elem_t ONE = mm4_pkg::ELEM_W'(1) << FRAC_BITS;

  mm4_pkg::elem_t [NUM-1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM; i++) begin
        mat[i]     <= (i % 5 == 0) ? ONE : '0;
        pending[i] <= '0;
      end
    end else begin
      if (load.wr) begin
        for (int r = 0; r < mm4_pkg::DIM; r++) begin
          mat[{load.col, 2'(r)}] <= load.data[r];
        end
      end
      if (pend.wr) begin
        for (int r = 0; r < mm4_pkg::DIM; r++) begin
          pending[{pend.col, 2'(r)}] <= pend.data[r];
        end
        // copy includes the column retiring this cycle
        if (pend.commit) begin
          for (int c = 0; c < mm4_pkg::DIM; c++) begin
            for (int r = 0; r < mm4_pkg::DIM; r++) begin
              mat[c * mm4_pkg::DIM + r] <= (c == int'(pend.col)) ?
                pend.data[r] : pending[c * mm4_pkg::DIM + r];
            end
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/matrix_multiply_4x4.sv -----
// 4x4 column-major transform matrix multiplier, signed fixed point.
// req: one column (elem_x..elem_w), col_index, opcode, commit per beat.
//   A load beat writes the column into the current matrix and gives no
//   output beat. A multiply beat gives one rsp beat: current matrix times
//   the column, rounded half up and saturated, with the saturated flag.
// rsp: out_col and res_x..res_w; valid/ready handshake.
// Pipeline: an accepted multiply beat is registered as products, then pair
//   sums, then the rounded result in the output register, which drives rsp.
// Throughput: one beat per cycle unless rsp stalls or a commit is in flight.
//   After a multiply with commit, req.ready stays low until that column
//   reaches the output register and the pending store is copied into the matrix.
// Reset (rst, synchronous): matrix to identity, pending store cleared,
//   pipeline emptied.
// Stall: while rsp.ready is low the pipeline holds; its three stages fill
//   and then req.ready drops. Load beats are taken only when the first
//   stage can move.
`include "matrix_multiply_4x4_defines.svh"

module matrix_multiply_4x4 #(
  parameter int FRAC_BITS = mm4_pkg::MM4_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  mm4_in_if.sink       req,
  mm4_out_if.source    rsp
);

  localparam int DIM = mm4_pkg::DIM;

  mm4_pkg::elem_t [DIM*DIM-1:0] mat;
  mm4_pkg::elem_t [DIM-1:0]     vec;
  mm4_pkg::elem_t [DIM-1:0]     lane_res;
  logic [DIM-1:0]               lane_clip;
  mm4_pkg::col_wr_t             load;
  mm4_pkg::pend_wr_t            pend;

  logic       a_valid, b_valid, c_valid;
  logic       a_commit, b_commit;
  logic [1:0] a_col, b_col, c_col;
  mm4_pkg::elem_t [DIM-1:0] c_res;
  logic       c_sat;
  logic       en_a, en_b, en_c, busy, acc, mul_acc;

  assign vec = {req.elem_w, req.elem_z, req.elem_y, req.elem_x};

  always_comb begin
    en_c      = !c_valid || rsp.ready;
    en_b      = !b_valid || en_c;
    en_a      = !a_valid || en_b;
    busy      = (a_valid && a_commit) || (b_valid && b_commit);
    req.ready = en_a && !busy;
    acc       = req.valid && req.ready;
    mul_acc   = acc && (mm4_pkg::opcode_t'(req.opcode) == mm4_pkg::OP_MUL);

    load.wr   = acc && (mm4_pkg::opcode_t'(req.opcode) == mm4_pkg::OP_LOAD);
    load.col  = req.col_index;
    load.data = vec;

    pend.wr     = en_c && b_valid;
    pend.commit = b_commit;
    pend.col    = b_col;
    pend.data   = lane_res;
  end

  mm4_store #(.FRAC_BITS(FRAC_BITS)) u_store (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .pend (pend),
    .mat  (mat)
  );

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    mm4_pkg::elem_t [DIM-1:0] row;
    for (genvar k = 0; k < DIM; k++) begin : g_row
      assign row[k] = mat[k * DIM + r];
    end
    mm4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .en_a (en_a),
      .en_b (en_b),
      .m    (row),
      .v    (vec),
      .res  (lane_res[r]),
      .clip (lane_clip[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= mul_acc;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
      if (en_c) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_col    <= req.col_index;
      a_commit <= req.commit;
    end
    if (en_b) begin
      b_col    <= a_col;
      b_commit <= a_commit;
    end
    if (en_c) begin
      c_col <= b_col;
      c_res <= lane_res;
      c_sat <= |lane_clip;
    end
  end

  assign rsp.valid     = c_valid;
  assign rsp.out_col   = c_col;
  assign rsp.res_x     = c_res[0];
  assign rsp.res_y     = c_res[1];
  assign rsp.res_z     = c_res[2];
  assign rsp.res_w     = c_res[3];
  assign rsp.saturated = c_sat;

  `MM4_ASSERT(no_accept_during_commit, busy |-> !req.ready)
  `MM4_ASSERT(mul_enters_pipe, mul_acc |=> a_valid)
  `MM4_ASSERT(commit_retire_frees, (en_c && b_valid && b_commit && !a_valid) |=> !busy)
  `MM4_ASSERT_RST(reset_empties, rst |=> (!a_valid && !b_valid && !c_valid))

endmodule
